>>> rtl/dpts_pkg.sv
// Shared constants, types and table functions for the decaying partial tone synthesiser.
`timescale 1ns / 1ps
`default_nettype none
package dpts_pkg;

	localparam int unsigned SAMPLE_RATE     = 48000;
	localparam int          SINE_TABLE_BITS = 10;
	localparam int          SAMPLE_BITS     = 16;

	localparam int QTR_STEPS = 1 << (SINE_TABLE_BITS - 2);
	localparam int IDX_W     = SINE_TABLE_BITS - 1;
	localparam int RND_SHIFT = 56 - SAMPLE_BITS;

	localparam int NUM_W     = 52;
	localparam int DEN_W     = 32;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam logic [24:0] ONE_Q24 = 25'h100_0000;

	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] SIN_C1  = 64'd1686629713;
	localparam logic [63:0] SIN_C3  = 64'd693598669;
	localparam logic [63:0] SIN_C5  = 64'd85569306;
	localparam logic [63:0] SIN_C7  = 64'd5026995;
	localparam logic [63:0] SIN_C9  = 64'd172272;

	localparam logic [NUM_W-1:0] INC_BIAS = NUM_W'(8 * SAMPLE_RATE);
	localparam logic [DEN_W-1:0] INC_DEN  = DEN_W'(16 * SAMPLE_RATE);
	localparam logic [DEN_W-1:0] RND_DEN  = DEN_W'(10);

	localparam longint SAT_HI_L  = ((64'sd1 <<< (SAMPLE_BITS - 1)) - 1 > 32767) ? 32767 :
		((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam longint SAT_LO_L  = ((64'sd1 <<< (SAMPLE_BITS - 1)) > 32768) ? 32768 :
		(64'sd1 <<< (SAMPLE_BITS - 1));
	localparam logic [NUM_W-1:0] SAT_HI     = NUM_W'(SAT_HI_L);
	localparam logic [NUM_W-1:0] SAT_LO_MAG = NUM_W'(SAT_LO_L);

	typedef logic [15:0] sine_tab_t [0:QTR_STEPS];
	typedef logic [23:0] mult_arr_t [0:2];

	typedef struct packed {
		logic       neg;
		logic [15:0] mag;
	} sine_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b;
		return p >> 30;
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] p;
		logic [63:0] mag;
		for (int j = 0; j <= QTR_STEPS; j++) begin
			u   = 64'(j) << (32 - SINE_TABLE_BITS);
			u2  = mul_q30(u, u);
			p   = SIN_C7 - mul_q30(u2, SIN_C9);
			p   = SIN_C5 - mul_q30(u2, p);
			p   = SIN_C3 - mul_q30(u2, p);
			p   = SIN_C1 - mul_q30(u2, p);
			p   = mul_q30(u, p);
			mag = (p + 64'd16384) >> 15;
			tab[j] = mag[15:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

	function automatic sine_t sine_lookup(input logic [31:0] phase);
		logic [SINE_TABLE_BITS-1:0] k;
		logic [1:0]                 quarter;
		logic [IDX_W-1:0]           r;
		logic [IDX_W-1:0]           j;
		sine_t                      s;
		k       = phase[31 -: SINE_TABLE_BITS];
		quarter = k[SINE_TABLE_BITS-1 -: 2];
		r       = {1'b0, k[SINE_TABLE_BITS-3:0]};
		j       = quarter[0] ? (IDX_W'(QTR_STEPS) - r) : r;
		s.neg   = quarter[1];
		s.mag   = SINE_TAB[j];
		return s;
	endfunction

	function automatic logic [23:0] decay_mult(input logic [63:0] k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] x3;
		logic [63:0] e;
		x  = ((k << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
		x2 = (x * x) >> 32;
		x3 = (x2 * x) >> 32;
		e  = (64'd1 << 32) - x + x2 / 64'd2 - x3 / 64'd6;
		return e[31:8];
	endfunction

	localparam mult_arr_t DECAY_MULT = '{decay_mult(64'd1), decay_mult(64'd25), decay_mult(64'd81)};

endpackage
`default_nettype wire

>>> rtl/dpts_if.sv
// Handshake channels for tick words in and sample words out.
`timescale 1ns / 1ps
`default_nettype none
interface dpts_item_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] seg_start;
	logic [31:0] seg_end;
	logic [15:0] amp_start;
	logic [15:0] amp_end;
	logic [18:0] freq_start;
	logic [18:0] freq_end;

	modport source (output valid, op, seg_start, seg_end, amp_start, amp_end, freq_start,
		freq_end, input ready);
	modport sink (input valid, op, seg_start, seg_end, amp_start, amp_end, freq_start,
		freq_end, output ready);
endinterface

interface dpts_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               segment_last;

	modport source (output valid, sample, segment_last, input ready);
	modport sink (input valid, sample, segment_last, output ready);
endinterface
`default_nettype wire

>>> rtl/dpts_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dpts_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dpts_pkg::div_req_t req,
	output dpts_pkg::div_rsp_t     rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [dpts_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [dpts_pkg::NUM_W-1:0]       num_q;
	logic [dpts_pkg::DEN_W-1:0]       den_q;
	logic [dpts_pkg::DEN_W-1:0]       rem_q;
	logic [dpts_pkg::DEN_W:0]         trial;
	logic                             fits;

	assign trial = {rem_q, num_q[dpts_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dpts_pkg::DIV_CNT_W'(dpts_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? dpts_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[dpts_pkg::DEN_W-1:0];
			num_q <= {num_q[dpts_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule
`default_nettype wire

>>> rtl/decaying_partial_tone_synth_top.sv
// Top level of the decaying partial tone synthesiser: sequencer, shared datapath and output register.
`timescale 1ns / 1ps
`default_nettype none
// Each tick word that yields a sample passes the sequencer to the output register;
// the interpolations are skipped when the sample time lies at or before the segment start.
// The work is done by the bit-serial shift-and-add multiplier (32 steps for each
// interpolation, 16 for the amplitude) and by the one-bit-per-cycle divider, which runs
// 52 steps for each interpolation, for the output rounding and for the phase increment.
// A tick at or past the segment end stops at the check, a reset word at idle. A new word is
// taken once the previous one is finished, while its sample may still wait in the output.
module decaying_partial_tone_synth_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	dpts_item_if.sink      item,
	dpts_result_if.source  result
);

	localparam int MC_W      = 58;
	localparam int CNT_W     = 6;
	localparam int SUM_W     = 44;
	localparam int LMUL_STEPS = 32;
	localparam int VMUL_STEPS = 16;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_LSET, ST_LMUL, ST_DIV, ST_SINE, ST_VSET, ST_VMUL,
		ST_RGO, ST_DECAY, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DK_LERP, DK_ROUND, DK_INC
	} div_kind_t;

	typedef logic [24:0] decay_arr_t [0:2];

	state_t      state_q;
	div_kind_t   kind_q;

	logic [31:0] t_q;
	logic [31:0] phase_q;
	decay_arr_t  decay_q;

	logic [31:0] seg_start_q;
	logic [31:0] seg_end_q;
	logic [15:0] amp_start_q;
	logic [15:0] amp_end_q;
	logic [18:0] freq_start_q;
	logic [18:0] freq_end_q;

	logic        last_q;
	logic        before_q;
	logic [31:0] ph5_q;
	logic [31:0] ph9_q;
	logic        sel_q;
	logic        dneg_q;
	logic [15:0] amp_q;
	logic [18:0] freq_q;

	logic [MC_W-1:0]  mc_q;
	logic [31:0]      mp_q;
	logic [MC_W-1:0]  acc_q;
	logic [CNT_W-1:0] cnt_q;

	logic [24:0] mul_a_q;
	logic [24:0] mul_b_q;
	logic [49:0] prod_q;
	logic        sgn_a_q;
	logic        sgn_p_q;
	logic signed [SUM_W-1:0] sum_q;
	logic        vneg_q;
	logic [15:0] res_q;
	logic [31:0] inc_q;

	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic        out_last_q;

	logic                       div_start_q;
	logic [dpts_pkg::NUM_W-1:0] div_num_q;
	logic [dpts_pkg::DEN_W-1:0] div_den_q;
	dpts_pkg::div_req_t         div_req;
	dpts_pkg::div_rsp_t         div_rsp;

	logic [19:0]              a0_w;
	logic [19:0]              a1_w;
	logic signed [20:0]       diff_w;
	logic [19:0]              dmag_w;
	logic [19:0]              lerp_q_w;
	logic [19:0]              lerp_val_w;
	logic [31:0]              off_w;
	logic [31:0]              span_w;
	logic [MC_W-1:0]          acc_nxt;
	logic [31:0]              sel_phase_w;
	dpts_pkg::sine_t          sine_w;
	logic signed [SUM_W-1:0]  prod_ext_w;
	logic [SUM_W-1:0]         smag_w;
	logic [MC_W:0]            rnd_w;
	logic [dpts_pkg::NUM_W-1:0] q_w;
	logic [15:0]              res_w;
	logic [dpts_pkg::NUM_W-1:0] inc_num_w;

	assign a0_w   = sel_q ? {1'b0, freq_start_q} : {4'b0, amp_start_q};
	assign a1_w   = sel_q ? {1'b0, freq_end_q} : {4'b0, amp_end_q};
	assign diff_w = $signed({1'b0, a1_w}) - $signed({1'b0, a0_w});
	assign dmag_w = diff_w[20] ? 20'(-diff_w) : diff_w[19:0];
	assign off_w  = t_q - seg_start_q;
	assign span_w = seg_end_q - seg_start_q;

	assign lerp_q_w   = div_rsp.quo[19:0];
	assign lerp_val_w = dneg_q ? (a0_w - lerp_q_w) : (a0_w + lerp_q_w);

	assign acc_nxt = mp_q[0] ? (acc_q + mc_q) : acc_q;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    sel_phase_w = phase_q;
			2'd1:    sel_phase_w = ph5_q;
			default: sel_phase_w = ph9_q;
		endcase
	end

	assign sine_w     = dpts_pkg::sine_lookup(sel_phase_w);
	assign prod_ext_w = $signed({3'b0, prod_q[40:0]});
	assign smag_w     = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	assign rnd_w = ({1'b0, acc_q} + ((MC_W + 1)'(5) << dpts_pkg::RND_SHIFT))
		>> dpts_pkg::RND_SHIFT;

	assign q_w = div_rsp.quo;
	always_comb begin
		if (vneg_q) begin
			res_w = (q_w > dpts_pkg::SAT_LO_MAG) ? 16'(-dpts_pkg::SAT_LO_MAG) : 16'(-q_w);
		end else begin
			res_w = (q_w > dpts_pkg::SAT_HI) ? 16'(dpts_pkg::SAT_HI) : 16'(q_w);
		end
	end

	assign inc_num_w = dpts_pkg::NUM_W'({freq_q, 32'b0}) + dpts_pkg::INC_BIAS;

	assign div_req.start = div_start_q;
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	dpts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= DK_LERP;
			t_q         <= '0;
			phase_q     <= '0;
			decay_q     <= '{dpts_pkg::ONE_Q24, dpts_pkg::ONE_Q24, dpts_pkg::ONE_Q24};
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			sgn_p_q     <= sgn_a_q;
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						seg_start_q  <= item.seg_start;
						seg_end_q    <= item.seg_end;
						amp_start_q  <= item.amp_start;
						amp_end_q    <= item.amp_end;
						freq_start_q <= item.freq_start;
						freq_end_q   <= item.freq_end;
						if (!item.op) begin
							t_q     <= '0;
							phase_q <= '0;
							decay_q <= '{dpts_pkg::ONE_Q24, dpts_pkg::ONE_Q24,
								dpts_pkg::ONE_Q24};
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (t_q >= seg_end_q) begin
						state_q <= ST_IDLE;
					end else begin
						last_q   <= (t_q + 32'd1) == seg_end_q;
						before_q <= t_q <= seg_start_q;
						ph5_q    <= phase_q + {phase_q[29:0], 2'b0};
						ph9_q    <= phase_q + {phase_q[28:0], 3'b0};
						sel_q    <= 1'b0;
						state_q  <= ST_LSET;
					end
				end
				ST_LSET: begin
					if (before_q) begin
						if (!sel_q) begin
							amp_q <= amp_start_q;
							sel_q <= 1'b1;
						end else begin
							freq_q  <= freq_start_q;
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_SINE;
						end
					end else begin
						mc_q    <= MC_W'(dmag_w);
						mp_q    <= off_w;
						acc_q   <= '0;
						cnt_q   <= '0;
						dneg_q  <= diff_w[20];
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL: begin
					acc_q <= acc_nxt;
					mc_q  <= mc_q << 1;
					mp_q  <= mp_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LMUL_STEPS - 1)) begin
						div_num_q   <= dpts_pkg::NUM_W'(acc_nxt);
						div_den_q   <= span_w;
						div_start_q <= 1'b1;
						kind_q      <= DK_LERP;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						unique case (kind_q)
							DK_LERP: begin
								if (!sel_q) begin
									amp_q   <= lerp_val_w[15:0];
									sel_q   <= 1'b1;
									state_q <= ST_LSET;
								end else begin
									freq_q  <= lerp_val_w[18:0];
									cnt_q   <= '0;
									sum_q   <= '0;
									state_q <= ST_SINE;
								end
							end
							DK_ROUND: begin
								res_q       <= res_w;
								div_num_q   <= inc_num_w;
								div_den_q   <= dpts_pkg::INC_DEN;
								div_start_q <= 1'b1;
								kind_q      <= DK_INC;
							end
							default: begin
								inc_q   <= q_w[31:0];
								cnt_q   <= '0;
								state_q <= ST_DECAY;
							end
						endcase
					end
				end
				ST_SINE: begin
					if (cnt_q < CNT_W'(3)) begin
						mul_a_q <= 25'(sine_w.mag);
						mul_b_q <= decay_q[cnt_q[1:0]];
						sgn_a_q <= sine_w.neg;
					end
					if (cnt_q >= CNT_W'(2)) begin
						sum_q <= sgn_p_q ? (sum_q - prod_ext_w) : (sum_q + prod_ext_w);
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(4)) begin
						state_q <= ST_VSET;
					end
				end
				ST_VSET: begin
					mc_q    <= MC_W'(smag_w);
					mp_q    <= {16'b0, amp_q};
					acc_q   <= '0;
					cnt_q   <= '0;
					vneg_q  <= sum_q[SUM_W-1];
					state_q <= ST_VMUL;
				end
				ST_VMUL: begin
					acc_q <= acc_nxt;
					mc_q  <= mc_q << 1;
					mp_q  <= mp_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(VMUL_STEPS - 1)) begin
						state_q <= ST_RGO;
					end
				end
				ST_RGO: begin
					div_num_q   <= dpts_pkg::NUM_W'(rnd_w);
					div_den_q   <= dpts_pkg::RND_DEN;
					div_start_q <= 1'b1;
					kind_q      <= DK_ROUND;
					state_q     <= ST_DIV;
				end
				ST_DECAY: begin
					if (cnt_q < CNT_W'(3)) begin
						mul_a_q <= decay_q[cnt_q[1:0]];
						mul_b_q <= 25'(dpts_pkg::DECAY_MULT[cnt_q[1:0]]);
					end
					if (cnt_q >= CNT_W'(2)) begin
						decay_q[cnt_q[1:0] - 2'd2] <= prod_q[48:24];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(4)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= res_q;
						out_last_q   <= last_q;
						t_q          <= t_q + 32'd1;
						phase_q      <= phase_q + inc_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item.ready          = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.sample       = $signed(out_sample_q);
	assign result.segment_last = out_last_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("Divider finished while the sequencer was not waiting for it.");

	a_word_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_EMIT))
		else $error("A sample word appeared without passing the emit step.");

	a_decay_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(decay_q[0] <= dpts_pkg::ONE_Q24) && (decay_q[1] <= dpts_pkg::ONE_Q24) &&
		(decay_q[2] <= dpts_pkg::ONE_Q24))
		else $error("A decay register grew above unity.");

endmodule
`default_nettype wire
